@@ src/zmn_pkg.sv @@
// Package: shared types, constants and FSM states for the 5x5 ZNCC map block.
`timescale 1ns / 1ps
package zmn_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned WinSide    = 5;
  localparam int unsigned WinArea    = WinSide * WinSide;
  localparam int unsigned LineCount  = WinSide - 1;
  localparam int unsigned ColW       = 11;
  localparam int unsigned RowW       = 12;
  localparam int unsigned CfgW       = 12;
  localparam int unsigned LineAddrW  = 13;  // line index (2b) and column (11b)
  localparam int unsigned LineDataW  = 16;  // plane and warped byte together
  localparam logic [CfgW-1:0] WidthReset = 12'd640;
  localparam int unsigned QBits      = 15;  // result search spans 0..16384

  typedef struct packed {
    logic [7:0] plane_pixel;
    logic [7:0] warped_pixel;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] correlation;
    logic [ColW-1:0]    center_col;
    logic [RowW-1:0]    center_row;
    logic               result_valid;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_SHIFT,
    ST_WR,
    ST_SUM,
    ST_MOM,
    ST_PROD,
    ST_PROD2,
    ST_SEARCH,
    ST_DONE
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic take_in;
    logic rd_line;
    logic shift_win;
    logic wr_line;
    logic sum_step;
    logic mom_calc;
    logic prod_calc;
    logic prod2_calc;
    logic search_init;
    logic search_step;
    logic finish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic rd_last;
    logic wr_last;
    logic sum_last;
    logic search_done;
  } sts_t;

endpackage

@@ src/zmn_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module zmn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ src/zmn_ctrl.sv @@
// Controller FSM sequencing the per-pixel steps of the ZNCC datapath.
`timescale 1ns / 1ps
module zmn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic            win_full_i,
  input  zmn_pkg::sts_t   sts_i,
  output zmn_pkg::cmd_t   cmd_o
);
  zmn_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zmn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      zmn_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = zmn_pkg::ST_RD;
        end
      end
      // read the four buffered lines at this column, one per cycle
      zmn_pkg::ST_RD: begin
        cmd_o.rd_line = 1'b1;
        if (sts_i.rd_last) state_d = zmn_pkg::ST_SHIFT;
      end
      zmn_pkg::ST_SHIFT: begin
        cmd_o.shift_win = 1'b1;
        state_d = zmn_pkg::ST_WR;
      end
      zmn_pkg::ST_WR: begin
        cmd_o.wr_line = 1'b1;
        if (sts_i.wr_last) begin
          state_d = win_full_i ? zmn_pkg::ST_SUM : zmn_pkg::ST_DONE;
        end
      end
      zmn_pkg::ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.sum_last) state_d = zmn_pkg::ST_MOM;
      end
      zmn_pkg::ST_MOM: begin
        cmd_o.mom_calc = 1'b1;
        state_d = zmn_pkg::ST_PROD;
      end
      zmn_pkg::ST_PROD: begin
        cmd_o.prod_calc = 1'b1;
        state_d = zmn_pkg::ST_PROD2;
      end
      zmn_pkg::ST_PROD2: begin
        cmd_o.prod2_calc  = 1'b1;
        cmd_o.search_init = 1'b1;
        state_d = zmn_pkg::ST_SEARCH;
      end
      zmn_pkg::ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.search_done) begin
          cmd_o.finish = 1'b1;
          state_d = zmn_pkg::ST_DONE;
        end
      end
      zmn_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = zmn_pkg::ST_IDLE;
      end
      default: state_d = zmn_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ src/zmn_dp.sv @@
// Datapath: line buffers, 5x5 windows, moment sums and ratio search.
`timescale 1ns / 1ps
module zmn_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  zmn_pkg::cmd_t             cmd_i,
  input  zmn_pkg::in_req_t          in_i,
  input  logic [zmn_pkg::CfgW-1:0]  width_i,
  output zmn_pkg::sts_t             sts_o,
  output logic                      win_full_o,
  output zmn_pkg::out_req_t         out_o
);
  localparam int unsigned LcW = $clog2(zmn_pkg::LineCount);
  localparam int unsigned AcW = $clog2(zmn_pkg::WinArea + 1);

  // Input latch and position counters
  logic [7:0] px_q, wx_q;
  logic [zmn_pkg::ColW-1:0] col_q, colcnt_q;
  logic [zmn_pkg::RowW-1:0] row_q;

  // Line read/write sequencing
  logic [LcW:0] lidx_q;
  logic [7:0] lp_q [zmn_pkg::LineCount];
  logic [7:0] lw_q [zmn_pkg::LineCount];
  logic [7:0] pw_q [zmn_pkg::WinArea];
  logic [7:0] ww_q [zmn_pkg::WinArea];

  logic ram_we;
  logic [zmn_pkg::LineAddrW-1:0] ram_addr;
  logic [zmn_pkg::LineDataW-1:0] ram_wd, ram_rd;
  logic rd_pend_q;
  logic [LcW-1:0] rd_slot_q;

  zmn_ram #(.Width(zmn_pkg::LineDataW), .Depth(zmn_pkg::LineCount * zmn_pkg::MaxWidth))
    u_lines (.clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd));

  // During read: line idx; during write: line idx gets next line (or new pixel)
  always_comb begin
    ram_we   = cmd_i.wr_line;
    ram_addr = {lidx_q[LcW-1:0], col_q};
    if (lidx_q[LcW-1:0] == LcW'(zmn_pkg::LineCount - 1)) begin
      ram_wd = {px_q, wx_q};
    end else begin
      ram_wd = {lp_q[lidx_q[LcW-1:0] + 1'b1], lw_q[lidx_q[LcW-1:0] + 1'b1]};
    end
  end

  assign sts_o.rd_last = cmd_i.rd_line && (lidx_q == (LcW+1)'(zmn_pkg::LineCount - 1));
  assign sts_o.wr_last = cmd_i.wr_line && (lidx_q == (LcW+1)'(zmn_pkg::LineCount - 1));

  logic [zmn_pkg::ColW:0] col_inc;
  logic [zmn_pkg::CfgW-1:0] w_sat;
  always_comb begin
    w_sat = width_i;
    if (width_i < zmn_pkg::CfgW'(zmn_pkg::WinSide)) w_sat = zmn_pkg::CfgW'(zmn_pkg::WinSide);
    if (width_i > zmn_pkg::CfgW'(zmn_pkg::MaxWidth)) w_sat = zmn_pkg::CfgW'(zmn_pkg::MaxWidth);
    col_inc = {1'b0, col_q} + 1'b1;
  end

  assign win_full_o = (col_q >= zmn_pkg::ColW'(zmn_pkg::LineCount)) &&
                      (row_q >= zmn_pkg::RowW'(zmn_pkg::LineCount));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colcnt_q  <= '0;
      row_q     <= '0;
      col_q     <= '0;
      lidx_q    <= '0;
      rd_pend_q <= 1'b0;
      rd_slot_q <= '0;
    end else begin
      rd_pend_q <= cmd_i.rd_line;
      rd_slot_q <= lidx_q[LcW-1:0];
      if (cmd_i.take_in) begin
        lidx_q <= '0;
        if (in_i.frame_start) begin
          col_q <= '0;
          row_q <= '0;
        end else begin
          col_q <= colcnt_q;
        end
      end
      if (cmd_i.rd_line) begin
        lidx_q <= sts_o.rd_last ? '0 : lidx_q + 1'b1;
      end
      if (cmd_i.wr_line) begin
        lidx_q <= lidx_q + 1'b1;
        if (sts_o.wr_last) begin
          // advance position after the line update
          if (col_inc >= w_sat) begin
            colcnt_q <= '0;
            if (row_q < zmn_pkg::RowW'(zmn_pkg::MaxHeight - 1)) row_q <= row_q + 1'b1;
          end else begin
            colcnt_q <= col_inc[zmn_pkg::ColW-1:0];
          end
        end
      end
    end
  end

  // Capture line reads and input pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      px_q <= in_i.plane_pixel;
      wx_q <= in_i.warped_pixel;
    end
    if (rd_pend_q) begin
      lp_q[rd_slot_q] <= ram_rd[15:8];
      lw_q[rd_slot_q] <= ram_rd[7:0];
    end
  end

  // Window shift: windows reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < zmn_pkg::WinArea; i++) begin
        pw_q[i] <= '0;
        ww_q[i] <= '0;
      end
    end else if (cmd_i.shift_win) begin
      for (int r = 0; r < zmn_pkg::WinSide; r++) begin
        for (int c = 0; c < zmn_pkg::WinSide - 1; c++) begin
          pw_q[r*zmn_pkg::WinSide + c] <= pw_q[r*zmn_pkg::WinSide + c + 1];
          ww_q[r*zmn_pkg::WinSide + c] <= ww_q[r*zmn_pkg::WinSide + c + 1];
        end
        if (r < zmn_pkg::LineCount - 1) begin
          pw_q[r*zmn_pkg::WinSide + zmn_pkg::WinSide - 1] <= lp_q[r];
          ww_q[r*zmn_pkg::WinSide + zmn_pkg::WinSide - 1] <= lw_q[r];
        end else if (r == zmn_pkg::LineCount - 1) begin
          // newest buffered line is still on the RAM read port this cycle
          pw_q[r*zmn_pkg::WinSide + zmn_pkg::WinSide - 1] <= ram_rd[15:8];
          ww_q[r*zmn_pkg::WinSide + zmn_pkg::WinSide - 1] <= ram_rd[7:0];
        end else begin
          pw_q[r*zmn_pkg::WinSide + zmn_pkg::WinSide - 1] <= px_q;
          ww_q[r*zmn_pkg::WinSide + zmn_pkg::WinSide - 1] <= wx_q;
        end
      end
    end
  end

  // Moment accumulation, one window element per cycle
  logic [AcW-1:0] acc_idx_q;
  logic [12:0] sx_q, sy_q;
  logic [20:0] sxx_q, syy_q, sxy_q;
  logic [7:0] ax, ay;
  assign ax = pw_q[acc_idx_q[4:0]];
  assign ay = ww_q[acc_idx_q[4:0]];
  assign sts_o.sum_last = cmd_i.sum_step &&
                          (acc_idx_q == AcW'(zmn_pkg::WinArea - 1));

  // Variance/covariance terms and ratio search
  logic signed [26:0] num_q;
  logic [25:0] vx_q, vy_q, a_q;
  logic        neg_q, flat_q;
  logic [51:0] p_q;
  logic [63:0] pl_q, ph_q;        // partial products of the variance product
  logic [82:0] t_q;               // a^2 * 2^30
  logic [zmn_pkg::QBits-1:0] lo_q, hi_q, mid_q;
  logic [zmn_pkg::QBits-1:0] mid;
  logic [zmn_pkg::QBits:0]   dd;
  logic [31:0] d2_q;              // (2*mid-1)^2
  logic [57:0] ml_q, mh_q;        // d2 times low and high halves of p
  logic [83:0] dp;
  logic [1:0]  sph_q;             // search step phase: square, multiply, compare

  assign mid = zmn_pkg::QBits'(({1'b0, lo_q} + {1'b0, hi_q} + 1'b1) >> 1);
  assign dd  = {mid, 1'b0} - 1'b1;
  assign dp  = 84'(ml_q) + (84'(mh_q) << 26);
  assign sts_o.search_done = cmd_i.search_step && (sph_q == 2'd0) && (lo_q >= hi_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) acc_idx_q <= '0;
    if (cmd_i.sum_step) begin
      if (acc_idx_q == '0) begin
        sx_q  <= 13'(ax);
        sy_q  <= 13'(ay);
        sxx_q <= 21'(16'(ax) * 16'(ax));
        syy_q <= 21'(16'(ay) * 16'(ay));
        sxy_q <= 21'(16'(ax) * 16'(ay));
      end else begin
        sx_q  <= sx_q + 13'(ax);
        sy_q  <= sy_q + 13'(ay);
        sxx_q <= sxx_q + 21'(16'(ax) * 16'(ax));
        syy_q <= syy_q + 21'(16'(ay) * 16'(ay));
        sxy_q <= sxy_q + 21'(16'(ax) * 16'(ay));
      end
      acc_idx_q <= acc_idx_q + 1'b1;
    end
    if (cmd_i.mom_calc) begin
      num_q <= $signed(27'(sxy_q) * 27'(zmn_pkg::WinArea)) - $signed(27'(26'(sx_q) * 26'(sy_q)));
      vx_q  <= 26'(26'(sxx_q) * 26'(zmn_pkg::WinArea)) - 26'(26'(sx_q) * 26'(sx_q));
      vy_q  <= 26'(26'(syy_q) * 26'(zmn_pkg::WinArea)) - 26'(26'(sy_q) * 26'(sy_q));
    end
    if (cmd_i.prod_calc) begin
      flat_q <= (vx_q == '0) || (vy_q == '0);
      neg_q  <= num_q[26];
      a_q    <= num_q[26] ? 26'(-num_q) : num_q[25:0];
      pl_q   <= 64'(vx_q) * 64'(vy_q[12:0]);
      ph_q   <= 64'(vx_q) * 64'(vy_q[25:13]);
    end
    if (cmd_i.prod2_calc) begin
      p_q <= 52'(pl_q + (ph_q << 13));
      t_q <= 83'(64'(a_q) * 64'(a_q)) << 30;
    end
    // each search step: square the candidate, multiply by p, then compare
    if (cmd_i.search_init) begin
      lo_q  <= '0;
      hi_q  <= zmn_pkg::QBits'(16384);
      sph_q <= 2'd0;
    end else if (cmd_i.search_step && !sts_o.search_done) begin
      unique case (sph_q)
        2'd0: begin
          mid_q <= mid;
          d2_q  <= 32'(dd) * 32'(dd);
          sph_q <= 2'd1;
        end
        2'd1: begin
          ml_q  <= 58'(d2_q) * 58'(p_q[25:0]);
          mh_q  <= 58'(d2_q) * 58'(p_q[51:26]);
          sph_q <= 2'd2;
        end
        default: begin
          if (dp <= 84'(t_q)) lo_q <= mid_q;
          else                hi_q <= mid_q - 1'b1;
          sph_q <= 2'd0;
        end
      endcase
    end
  end

  // Result register, cleared for items outside the full-window area
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o <= '0;
    end else if (cmd_i.wr_line && sts_o.wr_last) begin
      out_o.correlation  <= '0;
      out_o.center_col   <= win_full_o ? col_q - zmn_pkg::ColW'(2) : '0;
      out_o.center_row   <= win_full_o ? row_q - zmn_pkg::RowW'(2) : '0;
      out_o.result_valid <= win_full_o;
    end else if (cmd_i.finish) begin
      out_o.correlation <= flat_q ? '0 : (neg_q ? 16'(-{1'b0, lo_q}) : {1'b0, lo_q});
    end
  end
endmodule

@@ src/zero_mean_ncc_map_5x5.sv @@
// Top level of the 5x5 zero-mean normalized cross-correlation map block.
`timescale 1ns / 1ps
// Takes one plane/warped pixel pair per request and returns one result per
// request. Each pixel takes 4 line-buffer reads, a window shift and 4 writes;
// interior pixels add the accumulation of the 25 window elements, the product
// setup steps and a binary search for the Q1.14 ratio of up to 15 steps,
// each a square, a multiply and a compare, plus a final check. The block takes
// no new pixel until the result of the last one has been taken, so an output
// stall also holds the input; the single-port line-buffer RAM, the serial
// moment accumulator and the multi-cycle search step set the time per pixel.
// Line-buffer contents are undefined after reset; no clearing pass is done.
// image_width must be written only while the block is idle.
module zero_mean_ncc_map_5x5 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  zmn_pkg::in_req_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output zmn_pkg::out_req_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [zmn_pkg::CfgW-1:0]   cfg_wdata_i
);
  zmn_pkg::cmd_t cmd;
  zmn_pkg::sts_t sts;
  logic win_full;
  logic [zmn_pkg::CfgW-1:0] width_q;

  // width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= zmn_pkg::WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  zmn_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .win_full_i(win_full), .sts_i(sts), .cmd_o(cmd)
  );

  zmn_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i(in_data_i), .width_i(width_q),
    .sts_o(sts), .win_full_o(win_full), .out_o(out_data_o)
  );

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output both open");
  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.correlation) <= 16384 &&
                     $signed(out_data_o.correlation) >= -16384))
    else $error("correlation out of range");
  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.result_valid) |-> (out_data_o.correlation == '0))
    else $error("border result not zero");
`endif
endmodule

@@ tb/zero_mean_ncc_map_5x5_tb.sv @@
// Testbench for the 5x5 zero-mean NCC map block: directed frames and random pixel streams against a predictor.
`timescale 1ns / 1ps

// Predicts the block's results and checks them in order.
class ncc_scoreboard;
  localparam int Side = zmn_pkg::WinSide;
  localparam int Area = zmn_pkg::WinArea;
  localparam int Lines = zmn_pkg::LineCount;

  byte unsigned plane_buf[Lines][zmn_pkg::MaxWidth];
  byte unsigned warp_buf[Lines][zmn_pkg::MaxWidth];
  byte unsigned plane_win[Area];
  byte unsigned warp_win[Area];
  int unsigned col_cnt;
  int unsigned row_cnt;
  int unsigned width_reg;
  zmn_pkg::out_req_t pending[$];
  int errors;
  int checked;

  function new();
    foreach (plane_buf[r, c]) begin
      plane_buf[r][c] = 0;
      warp_buf[r][c] = 0;
    end
    foreach (plane_win[i]) begin
      plane_win[i] = 0;
      warp_win[i] = 0;
    end
    col_cnt = 0;
    row_cnt = 0;
    width_reg = zmn_pkg::WidthReset;
    errors = 0;
    checked = 0;
  endfunction

  function void set_width(logic [zmn_pkg::CfgW-1:0] v);
    width_reg = v;
  endfunction

  // round(16384 * |num| / sqrt(vx*vy)) with sign, zero for a flat window
  function logic signed [15:0] window_ncc();
    longint sx, sy, sxx, syy, sxy, num, vx, vy;
    logic [127:0] target, lhs, p, d;
    longint unsigned lo_q, hi_q, mid;
    sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
    for (int i = 0; i < Area; i++) begin
      sx += plane_win[i];
      sy += warp_win[i];
      sxx += plane_win[i] * plane_win[i];
      syy += warp_win[i] * warp_win[i];
      sxy += plane_win[i] * warp_win[i];
    end
    num = Area * sxy - sx * sy;
    vx = Area * sxx - sx * sx;
    vy = Area * syy - sy * sy;
    if (vx <= 0 || vy <= 0) return 16'sd0;
    if (num < 0) num = -num;
    target = (128'(num) * 128'(num)) << 30;
    p = 128'(vx) * 128'(vy);
    lo_q = 0;
    hi_q = 16384;
    while (lo_q < hi_q) begin
      mid = (lo_q + hi_q + 1) / 2;
      d = 128'(2 * mid - 1);
      lhs = d * d * p;
      if (lhs <= target) lo_q = mid;
      else hi_q = mid - 1;
    end
    if (Area * sxy - sx * sy < 0) return -16'(lo_q);
    return 16'(lo_q);
  endfunction

  // Accepted request: advance the model state and queue the expected result.
  function void note_request(zmn_pkg::in_req_t req);
    int unsigned w, col;
    zmn_pkg::out_req_t res;
    w = width_reg;
    if (w < Side) w = Side;
    if (w > zmn_pkg::MaxWidth) w = zmn_pkg::MaxWidth;
    if (req.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt % zmn_pkg::MaxWidth;
    // slide window, new column enters on the right
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side - 1; c++) begin
        plane_win[r*Side+c] = plane_win[r*Side+c+1];
        warp_win[r*Side+c] = warp_win[r*Side+c+1];
      end
      if (r < Lines) begin
        plane_win[r*Side+Side-1] = plane_buf[r][col];
        warp_win[r*Side+Side-1] = warp_buf[r][col];
      end else begin
        plane_win[r*Side+Side-1] = req.plane_pixel;
        warp_win[r*Side+Side-1] = req.warped_pixel;
      end
    end
    for (int r = 0; r < Lines - 1; r++) begin
      plane_buf[r][col] = plane_buf[r+1][col];
      warp_buf[r][col] = warp_buf[r+1][col];
    end
    plane_buf[Lines-1][col] = req.plane_pixel;
    warp_buf[Lines-1][col] = req.warped_pixel;

    res = '0;
    if (col >= Lines && row_cnt >= Lines) begin
      res.correlation = window_ncc();
      res.center_col = zmn_pkg::ColW'(col - 2);
      res.center_row = zmn_pkg::RowW'(row_cnt - 2);
      res.result_valid = 1'b1;
    end
    pending.insert(pending.size(), res);

    if (col + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt < zmn_pkg::MaxHeight - 1) row_cnt++;
    end else begin
      col_cnt = col + 1;
    end
  endfunction

  task report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %0d: %s got %0d want %0d", checked, what, got, want);
  endtask

  task check_result(zmn_pkg::out_req_t got);
    zmn_pkg::out_req_t want;
    if (pending.size() == 0) begin
      report_mismatch("unexpected result, valid", got.result_valid, 0);
      return;
    end
    want = pending.pop_front();
    if (got.correlation !== want.correlation)
      report_mismatch("correlation", got.correlation, want.correlation);
    if (got.center_col !== want.center_col)
      report_mismatch("center_col", got.center_col, want.center_col);
    if (got.center_row !== want.center_row)
      report_mismatch("center_row", got.center_row, want.center_row);
    if (got.result_valid !== want.result_valid)
      report_mismatch("result_valid", got.result_valid, want.result_valid);
    checked++;
  endtask
endclass

module zero_mean_ncc_map_5x5_tb;

  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  zmn_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  zmn_pkg::out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [zmn_pkg::CfgW-1:0] cfg_wdata = '0;

  ncc_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  bit calm = 1'b0;      // no random idling on either side while set
  bit hold_done = 1'b0;
  int hold_left = 0;
  int style = 0;

  zero_mean_ncc_map_5x5 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (!hold_done && sent >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(out_data);
  end

  // Valid stays up after acceptance; the next request or an idle cycle drops it
  task automatic send_request(zmn_pkg::in_req_t req);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(req);
    sent++;
  endtask

  task automatic write_width(logic [zmn_pkg::CfgW-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_width(v);
  endtask

  // Pixel pair of a given content style
  function automatic zmn_pkg::in_req_t make_pixel(int kind, bit fs);
    zmn_pkg::in_req_t r;
    r.plane_pixel = 8'($urandom_range(0, 255));
    case (kind)
      0: r.warped_pixel = 8'($urandom_range(0, 255));
      1: r.warped_pixel = r.plane_pixel ^ 8'($urandom_range(0, 3));
      2: r.warped_pixel = ~r.plane_pixel;
      3: begin
        r.plane_pixel = 8'($urandom_range(0, 1)) + 8'd127;
        r.warped_pixel = 8'($urandom_range(0, 255));
      end
      default: begin
        r.plane_pixel = 8'($urandom_range(0, 1) ? 255 : 0);
        r.warped_pixel = 8'($urandom_range(0, 1) ? 0 : 255);
      end
    endcase
    r.frame_start = fs;
    return r;
  endfunction

  // Random stream at one width; fresh frame first, rare restarts inside
  task automatic run_phase(logic [zmn_pkg::CfgW-1:0] w, int count);
    write_width(w);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) style = $urandom_range(0, 4);
      send_request(make_pixel(style, i == 0 || $urandom_range(0, 199) == 0));
    end
  endtask

  // Directed 5x5 frame: one full window, fixed relation between planes
  task automatic directed_frame(int kind);
    zmn_pkg::in_req_t r;
    for (int i = 0; i < 25; i++) begin
      r.plane_pixel = 8'(i * 10 + 5);
      case (kind)
        0: r.warped_pixel = r.plane_pixel;
        1: r.warped_pixel = ~r.plane_pixel;
        2: begin
          r.plane_pixel = 8'd0;
          r.warped_pixel = 8'd0;
        end
        default: begin
          r.plane_pixel = 8'd255;
          r.warped_pixel = 8'(i * 7);
        end
      endcase
      r.frame_start = (i == 0);
      send_request(r);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: perfect, inverse, flat both, flat plane; width below minimum
    write_width(12'd0);
    for (int k = 0; k < 4; k++) directed_frame(k);

    run_phase(12'd5, 120);
    calm = 1'b1;
    run_phase(12'd7, 120);
    calm = 1'b0;
    run_phase(12'd16, 150);
    run_phase(12'd33, 150);
    run_phase(12'd2048, 40);
    // width above the maximum saturates to the widest row
    run_phase(12'd4095, 40);
    run_phase(12'd6, 80);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
